/* rtl/uart_buffered_char_queues_top_assert.svh */
// Assertion macros shared by the character queue RTL.
`ifndef UART_BUFFERED_CHAR_QUEUES_TOP_ASSERT_SVH
`define UART_BUFFERED_CHAR_QUEUES_TOP_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define UBCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next cycle.
`define UBCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ubcq_pkg.sv */
// Constants and types for the buffered UART character queues.
package ubcq_pkg;

  localparam int TX_DEPTH = 8;
  localparam int RX_DEPTH = 8;

  localparam int TX_IDX_W = $clog2(TX_DEPTH);
  localparam int TX_PTR_W = TX_IDX_W + 1;
  localparam int RX_IDX_W = $clog2(RX_DEPTH);
  localparam int RX_PTR_W = RX_IDX_W + 1;

  localparam int RX_LEVEL_W = 4;
  localparam int OUT_W      = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    FUNC_PUT     = 2'd0,
    FUNC_TX_DONE = 2'd1,
    FUNC_RX_BYTE = 2'd2,
    FUNC_GET     = 2'd3
  } func_e;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic [OUT_W-27:0]      pad;
    logic                   rx_dropped;
    logic [RX_LEVEL_W-1:0]  rx_level;
    logic                   tx_busy;
    logic                   tx_full;
    logic                   put_accepted;
    logic                   read_valid;
    logic [7:0]             read_byte;
    logic                   tx_start;
    logic [7:0]             tx_byte;
  } result_t;

endpackage

/* rtl/uart_buffered_char_queues_top.sv */
// Buffered UART character queues: transmit and receive rings with put/get control.
//
// The block sits between software and a UART. Each transfer on the slave
// stream carries one operation in s_axis_tuser_i: put a character, report
// that the transmitter finished a byte, deliver a byte received from the
// line, or get the oldest received byte. The data byte rides in
// s_axis_tdata_i. Every operation produces exactly one result transfer on
// the master stream, holding the byte to start on the transmitter, the byte
// returned by a get, and the status of both queues after the operation.
// An accepted transfer passes through the input register, then the queue
// update, then the result register. Throughput is one operation per cycle
// while the result stream is not stalled, set by the single pass of pointer
// arithmetic and store accesses between those registers. When the receiver
// stalls, the result register holds its transfer and the input register
// keeps taking one more operation; after that s_axis_tready_o drops until
// the result is taken. Reset empties both queues, clears the transmitter
// active flag and turns carriage return insertion on. The insertion flag is
// written through cfg_wr_en_i and cfg_wr_data_i; the user must write it only
// while no operation is in flight, as the block does not enforce this.
module uart_buffered_char_queues_top
  import ubcq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: carriage return insertion before line feed.
  input  logic             cfg_wr_en_i,
  input  logic             cfg_wr_data_i,
  // Operation stream.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]       s_axis_tuser_i,   // [1:0] func
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [7:0] tx_byte, [8] tx_start, [16:9] read_byte, [17] read_valid,
  // [18] put_accepted, [19] tx_full, [20] tx_busy, [24:21] rx_level,
  // [25] rx_dropped, [31:26] zero
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  // Pointers run modulo twice the depth so that a full ring and an empty
  // ring have different levels.
  function automatic logic [TX_PTR_W-1:0] tx_inc(input logic [TX_PTR_W-1:0] p);
    return (p == TX_PTR_W'(2 * TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_IDX_W-1:0] tx_idx(input logic [TX_PTR_W-1:0] p);
    return (p >= TX_PTR_W'(TX_DEPTH)) ? TX_IDX_W'(p - TX_PTR_W'(TX_DEPTH))
                                      : TX_IDX_W'(p);
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_lvl(input logic [TX_PTR_W-1:0] h,
                                                 input logic [TX_PTR_W-1:0] t);
    logic [TX_PTR_W:0] wrapped;
    wrapped = {1'b0, t} + (TX_PTR_W + 1)'(2 * TX_DEPTH) - {1'b0, h};
    return (t >= h) ? t - h : TX_PTR_W'(wrapped);
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_inc(input logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(2 * RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RX_IDX_W-1:0] rx_idx(input logic [RX_PTR_W-1:0] p);
    return (p >= RX_PTR_W'(RX_DEPTH)) ? RX_IDX_W'(p - RX_PTR_W'(RX_DEPTH))
                                      : RX_IDX_W'(p);
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_lvl(input logic [RX_PTR_W-1:0] h,
                                                 input logic [RX_PTR_W-1:0] t);
    logic [RX_PTR_W:0] wrapped;
    wrapped = {1'b0, t} + (RX_PTR_W + 1)'(2 * RX_DEPTH) - {1'b0, h};
    return (t >= h) ? t - h : RX_PTR_W'(wrapped);
  endfunction

  // Input register.
  logic       in_valid_q;
  func_e      in_func_q;
  logic [7:0] in_data_q;

  // Result register.
  logic    out_valid_q;
  result_t out_data_q;

  // Queue state.
  logic [7:0]          tx_store [TX_DEPTH];
  logic [7:0]          rx_store [RX_DEPTH];
  logic [TX_PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [RX_PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic                active_q, active_d;
  logic                crlf_q;

  logic          advance;
  logic          process;
  result_t       res;
  logic [TX_PTR_W-1:0] tx_level;
  logic [RX_PTR_W-1:0] rx_level;
  logic [TX_PTR_W-1:0] tx_level_next;
  logic [RX_PTR_W-1:0] rx_level_next;

  // Store write controls; the transmit ring may take two bytes in one pass.
  logic       tx_wr0_en, tx_wr1_en;
  logic [7:0] tx_wr0_data;
  logic       rx_wr_en;
  logic       is_lf;
  logic [1:0] need;

  // The result register frees up when it is empty or being taken.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign tx_level = tx_lvl(tx_head_q, tx_tail_q);
  assign rx_level = rx_lvl(rx_head_q, rx_tail_q);

  always_comb begin
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    active_d    = active_q;
    tx_wr0_en   = 1'b0;
    tx_wr1_en   = 1'b0;
    rx_wr_en    = 1'b0;
    res         = '0;
    is_lf       = crlf_q && (in_data_q == CH_LF);
    // Bytes that must go into the ring: all of them when the transmitter is
    // busy, all but the first one otherwise.
    need        = {1'b0, active_q} + {1'b0, is_lf};
    // With the transmitter busy, an expanded line feed queues CR then LF.
    tx_wr0_data = (is_lf && active_q) ? CH_CR : in_data_q;

    unique case (in_func_q)
      FUNC_PUT: begin
        if (({1'b0, tx_level} + (TX_PTR_W + 1)'(need)) <= (TX_PTR_W + 1)'(TX_DEPTH)) begin
          res.put_accepted = 1'b1;
          if (!active_q) begin
            active_d     = 1'b1;
            res.tx_byte  = is_lf ? CH_CR : in_data_q;
            res.tx_start = 1'b1;
            if (is_lf) begin
              tx_wr0_en = 1'b1;
              tx_tail_d = tx_inc(tx_tail_q);
            end
          end else begin
            tx_wr0_en = 1'b1;
            if (is_lf) begin
              tx_wr1_en = 1'b1;
              tx_tail_d = tx_inc(tx_inc(tx_tail_q));
            end else begin
              tx_tail_d = tx_inc(tx_tail_q);
            end
          end
        end
      end
      FUNC_TX_DONE: begin
        if (tx_level != '0) begin
          res.tx_byte  = tx_store[tx_idx(tx_head_q)];
          res.tx_start = 1'b1;
          tx_head_d    = tx_inc(tx_head_q);
        end else begin
          active_d = 1'b0;
        end
      end
      FUNC_RX_BYTE: begin
        if (rx_level < RX_PTR_W'(RX_DEPTH)) begin
          rx_wr_en  = 1'b1;
          rx_tail_d = rx_inc(rx_tail_q);
        end else begin
          res.rx_dropped = 1'b1;
        end
      end
      FUNC_GET: begin
        if (rx_level != '0) begin
          res.read_byte  = rx_store[rx_idx(rx_head_q)];
          res.read_valid = 1'b1;
          rx_head_d      = rx_inc(rx_head_q);
        end
      end
    endcase

    tx_level_next = tx_lvl(tx_head_d, tx_tail_d);
    rx_level_next = rx_lvl(rx_head_d, rx_tail_d);
    res.tx_full   = (tx_level_next >= TX_PTR_W'(TX_DEPTH));
    res.tx_busy   = active_d;
    res.rx_level  = RX_LEVEL_W'(rx_level_next);
  end

  // Control state and the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_func_q   <= FUNC_PUT;
      in_data_q   <= '0;
      out_valid_q <= 1'b0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      active_q    <= 1'b0;
      crlf_q      <= 1'b1;
    end else begin
      if (cfg_wr_en_i) begin
        crlf_q <= cfg_wr_data_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_func_q <= func_e'(s_axis_tuser_i);
        in_data_q <= s_axis_tdata_i;
      end
      if (process) begin
        out_valid_q <= 1'b1;
        tx_head_q   <= tx_head_d;
        tx_tail_q   <= tx_tail_d;
        rx_head_q   <= rx_head_d;
        rx_tail_q   <= rx_tail_d;
        active_q    <= active_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register and the two rings.
  always_ff @(posedge clk_i) begin
    if (process) begin
      out_data_q <= res;
      if (tx_wr0_en) begin
        tx_store[tx_idx(tx_tail_q)] <= tx_wr0_data;
      end
      if (tx_wr1_en) begin
        tx_store[tx_idx(tx_inc(tx_tail_q))] <= CH_LF;
      end
      if (rx_wr_en) begin
        rx_store[rx_idx(rx_tail_q)] <= in_data_q;
      end
    end
  end

`include "uart_buffered_char_queues_top_assert.svh"

  `UBCQ_ASSERT(a_tx_level_bound, tx_level <= TX_PTR_W'(TX_DEPTH), "transmit ring overfilled")
  `UBCQ_ASSERT(a_rx_level_bound, rx_level <= RX_PTR_W'(RX_DEPTH), "receive ring overfilled")
  `UBCQ_ASSERT(a_queued_means_busy, (tx_level == '0) || active_q,
               "bytes queued while transmitter idle")
  `UBCQ_ASSERT_NEXT(a_drop_only_when_full, process && res.rx_dropped,
                    rx_level == RX_PTR_W'(RX_DEPTH), "byte dropped from a ring with room")

endmodule
